FILE: sv/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern scanner
// Word types of the request and response channels, register indexes, and the
// pattern-select helpers used by every window cell.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PATTERN_MAX  = 16;
   localparam int ADDRESS_BITS = 48;

   // Holds a pattern length or a cell position, 0..PATTERN_MAX
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_REGION_BASE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_start;
      logic       region_end;
   } req_word_type;

   typedef struct packed {
      logic                    found;
      logic [ADDRESS_BITS-1:0] match_address;
      logic                    not_found;
   } rsp_word_type;

   // Pattern setup seen by every cell
   typedef struct packed {
      logic [63:0]      pattern_low;
      logic [63:0]      pattern_high;
      logic [15:0]      care_mask;
      logic [LEN_W-1:0] len_eff;
   } cell_cfg_type;

   // Pick pattern byte k; positions sixteen and above read as zero
   function automatic logic [7:0] pat_byte(cell_cfg_type cfg, logic [LEN_W-1:0] k);
      logic [127:0] pat;
      logic [7:0]   b;
      pat = {cfg.pattern_high, cfg.pattern_low};
      b   = 8'd0;
      for (int j = 0; j < 16; j++) begin
         if (int'(k) == j) begin
            b = pat[8*j +: 8];
         end
      end
      return b;
   endfunction

   // Care bit of pattern byte k; positions sixteen and above are wildcards
   function automatic logic pat_care(cell_cfg_type cfg, logic [LEN_W-1:0] k);
      logic c;
      c = 1'b0;
      for (int j = 0; j < 16; j++) begin
         if (int'(k) == j) begin
            c = cfg.care_mask[j];
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell: one window cell
// Compares the byte of its age against the pattern byte that lines up with it
// and hands the byte to the next-older cell on every accepted word.
// ----------------------------------------------------------------------------
module wbps_cell
   import wbps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  cell_cfg_type     cfg,
   input  logic [LEN_W-1:0] cell_index,
   input  logic [7:0]       byte_in,
   output logic [7:0]       byte_out,
   output logic             byte_ok
);

   logic [7:0]       byte_ff;
   logic             in_use;
   logic [LEN_W-1:0] pat_index;
   logic [7:0]       pat_value;
   logic             pat_cared;

   // Line up: byte of age a meets pattern byte len-1-a
   always_comb begin
      in_use    = cell_index < cfg.len_eff;
      pat_index = cfg.len_eff - cell_index - LEN_W'(1);
      pat_value = pat_byte(cfg, pat_index);
      pat_cared = pat_care(cfg, pat_index);
      byte_ok   = !in_use || !pat_cared || (pat_value == byte_in);
   end

   // Clear on reset, advance the window on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

FILE: sv/wildcard_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top: masked byte signature scanner
// Response words are registered in the output register, or in the skid stage
// while the response side stalls. Throughput: one byte per cycle, set by the
// row of window cells compared in parallel, while the skid stage is empty.
// Reset (synchronous, active high) empties both channels, loads the register
// defaults and clears the offset and found flag.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top
   import wbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [ADDRESS_BITS-1:0] OFFSET_MAX = '1;

   logic [63:0]             pattern_low_ff;
   logic [63:0]             pattern_high_ff;
   logic [15:0]             care_mask_ff;
   logic [4:0]              pattern_length_ff;
   logic [ADDRESS_BITS-1:0] region_base_ff;

   logic [ADDRESS_BITS-1:0] offset_ff, offset_in;
   logic                    seen_ff, seen_in;

   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;
   logic                    skid_valid_ff;
   rsp_word_type            skid_word_ff;

   cell_cfg_type            cell_cfg;
   logic [LEN_W-1:0]        len_m1;
   logic [7:0]              chain [0:PATTERN_MAX];
   logic [PATTERN_MAX-1:0]  cell_ok;

   logic                    accept;
   logic                    out_free;
   logic [ADDRESS_BITS-1:0] cur_off;
   logic                    seen_cur;
   logic                    hit;
   rsp_word_type            new_word;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= 5'd1;
         region_base_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_data;
            CSR_CARE_MASK:    care_mask_ff      <= csr_data[15:0];
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_data[4:0];
            CSR_REGION_BASE:  region_base_ff    <= csr_data[ADDRESS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the length to the window size and build the cell setup
   always_comb begin
      cell_cfg.pattern_low  = pattern_low_ff;
      cell_cfg.pattern_high = pattern_high_ff;
      cell_cfg.care_mask    = care_mask_ff;
      if (int'(pattern_length_ff) > PATTERN_MAX) begin
         cell_cfg.len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         cell_cfg.len_eff = LEN_W'(pattern_length_ff);
      end
      len_m1 = (cell_cfg.len_eff == '0) ? '0 : cell_cfg.len_eff - LEN_W'(1);
   end

   // Row of window cells; the newest byte enters at age zero
   assign chain[0] = req_word.data_byte;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .cfg        (cell_cfg),
         .cell_index (LEN_W'(g)),
         .byte_in    (chain[g]),
         .byte_out   (chain[g+1]),
         .byte_ok    (cell_ok[g])
      );
   end

   // Match decision, start address and region flags
   always_comb begin
      cur_off  = req_word.region_start ? '0 : offset_ff;
      seen_cur = req_word.region_start ? 1'b0 : seen_ff;
      hit      = (&cell_ok) && (cur_off >= ADDRESS_BITS'(len_m1));

      new_word.found         = hit && !seen_cur;
      new_word.match_address = '0;
      if (new_word.found) begin
         new_word.match_address = region_base_ff + cur_off - ADDRESS_BITS'(len_m1);
      end
      new_word.not_found = req_word.region_end && !(seen_cur || new_word.found);

      seen_in   = seen_cur || new_word.found;
      offset_in = (cur_off == OFFSET_MAX) ? cur_off : cur_off + ADDRESS_BITS'(1);
   end

   // Advance offset and found flag per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         seen_ff   <= 1'b0;
      end else if (accept) begin
         offset_ff <= offset_in;
         seen_ff   <= seen_in;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Load payload registers alongside the valid bits
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_word_ff <= skid_word_ff;
         end else if (accept) begin
            rsp_word_ff <= new_word;
         end
      end else if (accept) begin
         skid_word_ff <= new_word;
      end
   end

endmodule

FILE: tb/wbps_scan_checker.sv
// ----------------------------------------------------------------------------
// wbps_scan_checker: response checker for the wildcard byte pattern scanner
// Watches the register, request and response channels, keeps its own copy of
// the pattern setup and scan state, predicts one response word per request
// word and compares each response word with the oldest prediction.
// ----------------------------------------------------------------------------
module wbps_scan_checker
   import wbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_word_type           req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_count,
   output int                     reports_pending
);

   // Pattern setup as last written
   logic [63:0]             pat_low;
   logic [63:0]             pat_high;
   logic [15:0]             care;
   logic [4:0]              pat_len;
   logic [ADDRESS_BITS-1:0] base_addr;

   // Scan state: bytes before the current one, newest first
   logic [7:0]              recent_bytes [PATTERN_MAX-1];
   logic [ADDRESS_BITS-1:0] region_offset;
   logic                    hit_reported;

   rsp_word_type expected_reports [$];
   int           failures = 0;

   assign mismatch_count = failures;

   // Work out the response word for one byte and advance the scan state
   function automatic rsp_word_type predict_report(req_word_type w);
      rsp_word_type            r;
      int unsigned             len;
      logic                    hit;
      logic [ADDRESS_BITS-1:0] first_off;
      logic [127:0]            pat;
      logic [7:0]              b;
      int unsigned             age;
      pat       = {pat_high, pat_low};
      len       = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
      r         = '0;
      hit       = 1'b0;
      first_off = '0;
      if (w.region_start) begin
         region_offset = '0;
         hit_reported  = 1'b0;
      end
      if (len == 0) begin
         // an empty pattern matches at the current byte
         hit       = 1'b1;
         first_off = region_offset;
      end else if (region_offset >= len - 1) begin
         // only bytes of this region may take part
         hit = 1'b1;
         for (int k = 0; k < len; k++) begin
            age = len - 1 - k;
            b   = (age == 0) ? w.data_byte : recent_bytes[age-1];
            if (care[k] && pat[8*k +: 8] != b) begin
               hit = 1'b0;
            end
         end
         first_off = region_offset - (len - 1);
      end
      if (hit && !hit_reported) begin
         r.found         = 1'b1;
         r.match_address = base_addr + first_off;
         hit_reported    = 1'b1;
      end
      r.not_found = w.region_end && !hit_reported;
      // shift the window and advance the offset, saturating at the top
      for (int i = PATTERN_MAX - 2; i > 0; i--) begin
         recent_bytes[i] = recent_bytes[i-1];
      end
      recent_bytes[0] = w.data_byte;
      if (region_offset != '1) begin
         region_offset = region_offset + 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type fresh_report;
      if (reset) begin
         pat_low       = '0;
         pat_high      = '0;
         care          = 16'hFFFF;
         pat_len       = 5'd1;
         base_addr     = '0;
         recent_bytes  = '{default: '0};
         region_offset = '0;
         hit_reported  = 1'b0;
         expected_reports.delete();
      end else begin
         // mirror register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:  pat_low   = csr_data;
               CSR_PATTERN_HIGH: pat_high  = csr_data;
               CSR_CARE_MASK:    care      = csr_data[15:0];
               CSR_PATTERN_LEN:  pat_len   = csr_data[4:0];
               CSR_REGION_BASE:  base_addr = csr_data[ADDRESS_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fresh_report     = predict_report(req_word);
            expected_reports = {expected_reports, fresh_report};
         end
         // compare each response word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected response word: found=%0b addr=%h not_found=%0b",
                           rsp_word.found, rsp_word.match_address, rsp_word.not_found);
               end
            end else begin
               want = expected_reports.pop_front();
               if (rsp_word.found !== want.found ||
                   rsp_word.match_address !== want.match_address ||
                   rsp_word.not_found !== want.not_found) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch: want f=%0b a=%h nf=%0b, got f=%0b a=%h nf=%0b",
                              want.found, want.match_address, want.not_found,
                              rsp_word.found, rsp_word.match_address, rsp_word.not_found);
                  end
               end
            end
         end
      end
      reports_pending <= expected_reports.size();
   end

endmodule

FILE: tb/tb_wildcard_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner_top: stimulus and verdict for the scanner
// Writes pattern setups between phases, streams regions of bytes with planted
// pattern instances, regions that start inside an instance and loose noise,
// under bursty sending and patterned response stalls. The checker beside the
// block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner_top;
   import wbps_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BYTES   = 148;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_level_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   int                     mismatch_count;
   int                     reports_pending;

   // Stimulus view of the current pattern setup
   logic [127:0]    cur_pattern;
   logic [15:0]     cur_care;
   int              len_eff;
   logic [7:0]      run_bytes [$];
   int              bytes_sent  = 0;
   int              burst_left  = 0;
   int              gap_max     = 0;
   stall_level_type stall_level = STALL_NONE;
   int              idle_cycles = 0;
   logic [7:0]      stall_bits  = '0;
   int              stall_phase = 0;

   wildcard_byte_pattern_scanner_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   wbps_scan_checker scan_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response stalls: eight-bit patterns drawn at the current level, played out bit by bit
   always @(posedge clock) begin
      logic [7:0] fresh;
      if (stall_phase == 0) begin
         case (stall_level)
            STALL_NONE:  fresh = '0;
            STALL_LIGHT: fresh = 8'($urandom & $urandom);
            default:     fresh = 8'($urandom | $urandom);
         endcase
         rsp_stall   <= fresh[0];
         stall_bits  <= fresh >> 1;
         stall_phase <= 7;
      end else begin
         rsp_stall   <= stall_bits[0];
         stall_bits  <= stall_bits >> 1;
         stall_phase <= stall_phase - 1;
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Present one byte, hold it until taken, then maybe idle between bursts
   task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
      int gap;
      req_valid <= 1'b1;
      req_word  <= '{data_byte: b, region_start: s, region_end: e};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Send the built run, flagging the start byte and optionally the last one
   task automatic send_run(input int start_pos, input bit end_last);
      foreach (run_bytes[i]) begin
         send_byte(run_bytes[i], i == start_pos, end_last && i == run_bytes.size() - 1);
      end
   endtask

   // Stop sending and wait until every response word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load a full pattern setup; junk bits ride above the narrow fields
   task automatic configure(input logic [4:0] len, input logic [127:0] pat,
                            input logic [15:0] care, input logic [ADDRESS_BITS-1:0] base,
                            input bit junk_write);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      if (junk_write) begin
         write_reg(CSR_INDEX_W'(CSR_REGION_BASE + 1 + $urandom_range(0, 2)), junk);
      end
      write_reg(CSR_PATTERN_LOW, pat[63:0]);
      write_reg(CSR_PATTERN_HIGH, pat[127:64]);
      write_reg(CSR_CARE_MASK, {junk[63:16], care});
      write_reg(CSR_PATTERN_LEN, {junk[63:5], len});
      write_reg(CSR_REGION_BASE, {junk[63:ADDRESS_BITS], base});
      csr_valid   <= 1'b0;
      cur_pattern = pat;
      cur_care    = care;
      len_eff     = (len > PATTERN_MAX) ? PATTERN_MAX : len;
   endtask

   // Filler leans on pattern bytes so near misses are common
   function automatic logic [7:0] filler_byte();
      int k;
      if (len_eff > 0 && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, len_eff - 1);
         return cur_pattern[8*k +: 8];
      end
      return 8'($urandom);
   endfunction

   // Append one byte to the run being built
   task automatic append_byte(input logic [7:0] b);
      run_bytes = {run_bytes, b};
   endtask

   task automatic add_filler(input int n);
      repeat (n) append_byte(filler_byte());
   endtask

   // Append one pattern instance with random bytes in wildcard positions
   task automatic add_instance();
      if (len_eff == 0) begin
         append_byte(8'($urandom));
      end
      for (int k = 0; k < len_eff; k++) begin
         append_byte(cur_care[k] ? cur_pattern[8*k +: 8] : 8'($urandom));
      end
   endtask

   initial begin
      int          phase_end;
      int          n;
      int          at;
      int          pick;
      bit          paused;
      logic [4:0]  len;
      logic [127:0] pat;
      logic [15:0] care;
      logic [ADDRESS_BITS-1:0] base;

      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: one-byte pattern of zero, match reported once
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      drain();

      // Empty pattern at the top address; next byte carries on without a start
      configure(5'd0, '0, 16'h0000, '1, 1'b0);
      send_byte(8'hAB, 1'b1, 1'b1);
      send_byte(8'hCD, 1'b0, 1'b0);
      drain();

      // Oversized length clamps to sixteen; match start wraps past the top
      configure(5'd31, 128'hFE02_0000_FF11_EE3C_80FF_0001_7FA5_5AC3, 16'hBDFE,
                {{(ADDRESS_BITS-1){1'b1}}, 1'b0}, 1'b1);
      run_bytes.delete();
      append_byte(8'h11);
      append_byte(8'h22);
      add_instance();
      send_run(0, 1'b1);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // pick a setup, extremes first
         pat  = {$urandom, $urandom, $urandom, $urandom};
         care = 16'($urandom);
         base = ADDRESS_BITS'({$urandom, $urandom});
         case ($urandom_range(0, 5))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 8));
         endcase
         if ($urandom_range(0, 3) == 0) care = 16'hFFFF;
         if ($urandom_range(0, 5) == 0) base = '1 - ADDRESS_BITS'($urandom_range(0, 20));
         if (ph == 0) begin
            len = 5'd16; pat = '1; care = 16'hFFFF; base = '1;
         end else if (ph == 1) begin
            len = 5'd1; pat = '0; care = 16'h0000; base = '0;
         end
         configure(len, pat, care, base, 1'($urandom_range(0, 1)));

         // idling for this phase: none at all in the first one
         gap_max     = (ph == 0) ? 0 : (ph == 1) ? 10 : $urandom_range(0, 1) * 3;
         stall_level = (ph == 0) ? STALL_NONE : (ph == 1) ? STALL_HEAVY :
                       stall_level_type'($urandom_range(0, 2));

         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            run_bytes.delete();
            if (pick < 65) begin
               // well-formed region, often holding a planted instance
               n = $urandom_range(1, 48);
               if ($urandom_range(0, 9) < 6 && len_eff <= n) begin
                  at = $urandom_range(0, n - ((len_eff > 0) ? len_eff : 1));
                  add_filler(at);
                  add_instance();
                  add_filler(n - at - ((len_eff > 0) ? len_eff : 1));
               end else begin
                  add_filler(n);
               end
               send_run(0, $urandom_range(0, 9) != 0);
            end else if (pick < 80 && len_eff >= 2) begin
               // region starts inside an instance; its head must not count
               add_instance();
               add_filler($urandom_range(0, 4));
               send_run($urandom_range(1, len_eff - 1), 1'b1);
            end else begin
               // loose bytes with stray flags
               repeat ($urandom_range(1, 6)) begin
                  send_byte(filler_byte(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
               end
            end
            if (ph == 3 && !paused && bytes_sent >= phase_end - PHASE_BYTES / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: wildcard_byte_pattern_scanner_top.f
sv/wbps_pkg.sv
sv/wbps_cell.sv
sv/wildcard_byte_pattern_scanner_top.sv
tb/wbps_scan_checker.sv
tb/tb_wildcard_byte_pattern_scanner_top.sv
